### sv/mrfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_pkg
// Shared types, codes and the CRC-16 byte update for the Modbus RTU receiver.
// ----------------------------------------------------------------------------
package mrfr_pkg;

   // input commands
   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_EOF     = 2'd1;
   localparam logic [1:0] CMD_EOF_ERR = 2'd2;

   // verdict codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CRC_ERR   = 3'd1;
   localparam logic [2:0] ST_TOO_SHORT = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_LINE_ERR  = 3'd4;

   // result kinds
   localparam logic KIND_ECHO    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // receiver phases
   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RECV = 2'd1;
   localparam logic [1:0] PH_SKIP = 2'd2;

   // configuration register indexes
   localparam logic CSR_SLAVE_MODE  = 1'b0;
   localparam logic CSR_OWN_ADDRESS = 1'b1;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic       slave_mode;
      logic [7:0] own_address;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  position;
      logic [7:0]  byte_value;
      logic [2:0]  status;
      logic [7:0]  frame_address;
      logic [7:0]  function_code;
      logic [7:0]  data_length;
      logic [15:0] computed_crc;
   } result_type;

   // reflected CRC-16, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### sv/mrfr_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_in_stage
// Input register: captures one item and holds it until the frame core takes it.
// ----------------------------------------------------------------------------
module mrfr_in_stage
   import mrfr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire item_type req_item,
   output logic          in_valid,
   output item_type      in_item,
   input  wire logic     take
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_ready = !valid_ff || take;
   assign in_valid  = valid_ff;
   assign in_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule
`default_nettype wire

### sv/mrfr_frame_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrfr_frame_core
// Frame state, CRC accumulation, echo and verdict logic, and result register.
// ----------------------------------------------------------------------------
module mrfr_frame_core
   import mrfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     in_valid,
   input  wire item_type in_item,
   output logic          take,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output result_type    rsp_result
);

   localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
   localparam int DW = (CW > 8) ? CW : 8;

   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   crc_ff, crc_in;
   logic [15:0]   held_ff, held_in;
   logic [7:0]    addr_ff, addr_in;
   logic [7:0]    func_ff, func_in;
   logic          ovf_ff, ovf_in;

   logic          rsp_valid_ff;
   result_type    result_ff;
   logic          res_valid;
   result_type    res;

   logic [DW-1:0] dlen_w;
   logic [15:0]   rx_crc;

   assign take       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   assign dlen_w = DW'(count_ff) - DW'(4);
   // CRC travels low byte first, so the older held byte is the low half
   assign rx_crc = {held_ff[7:0], held_ff[15:8]};

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      held_in   = held_ff;
      addr_in   = addr_ff;
      func_in   = func_ff;
      ovf_in    = ovf_ff;
      res_valid = 1'b0;
      res       = '0;
      if (in_valid && take) begin
         unique case (in_item.command)
            CMD_BYTE: begin
               if (phase_ff != PH_SKIP) begin
                  if (phase_ff == PH_IDLE && cfg.slave_mode &&
                      in_item.rx_byte != cfg.own_address) begin
                     phase_in = PH_SKIP;
                  end else begin
                     // idle state is always clear, so count is zero here
                     if (phase_ff == PH_IDLE) begin
                        phase_in = PH_RECV;
                        addr_in  = in_item.rx_byte;
                     end
                     if (count_ff >= CW'(MAX_FRAME_BYTES)) begin
                        ovf_in = 1'b1;
                     end else begin
                        if (count_ff == CW'(1)) begin
                           func_in = in_item.rx_byte;
                        end
                        if (count_ff >= CW'(2)) begin
                           crc_in = crc16_byte(crc_ff, held_ff[15:8]);
                        end
                        held_in        = {held_ff[7:0], in_item.rx_byte};
                        count_in       = count_ff + CW'(1);
                        res_valid      = 1'b1;
                        res.kind       = KIND_ECHO;
                        res.position   = 8'(count_ff);
                        res.byte_value = in_item.rx_byte;
                     end
                  end
               end
            end
            CMD_EOF, CMD_EOF_ERR: begin
               if (phase_ff == PH_RECV) begin
                  res_valid         = 1'b1;
                  res.kind          = KIND_VERDICT;
                  res.frame_address = addr_ff;
                  res.function_code = func_ff;
                  if (in_item.command == CMD_EOF_ERR) begin
                     res.status = ST_LINE_ERR;
                  end else if (count_ff < CW'(4)) begin
                     res.status = ST_TOO_SHORT;
                  end else if (ovf_ff) begin
                     res.status = ST_TOO_LONG;
                  end else begin
                     res.status       = (rx_crc == crc_ff) ? ST_OK : ST_CRC_ERR;
                     res.computed_crc = crc_ff;
                     res.data_length  = (dlen_w > DW'(255)) ? 8'hFF : 8'(dlen_w);
                  end
                  count_in = '0;
                  crc_in   = CRC_INIT;
                  held_in  = '0;
                  addr_in  = '0;
                  func_in  = '0;
                  ovf_in   = 1'b0;
               end
               phase_in = PH_IDLE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         crc_ff       <= CRC_INIT;
         held_ff      <= '0;
         addr_ff      <= '0;
         func_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
         held_ff  <= held_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         ovf_ff   <= ovf_in;
         if (take) begin
            rsp_valid_ff <= in_valid && res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         result_ff <= res;
      end
   end

endmodule
`default_nettype wire

### sv/modbus_rtu_frame_receiver_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modbus_rtu_frame_receiver_unit
// Modbus RTU frame receiver: byte echo, address filter and CRC-16 verdict.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per handshake: a received byte or an end of frame
//   (with or without line error). rsp_* returns at most one result per item:
//   an echo of an accepted byte with its position, or the frame verdict.
//   csr_* writes slave_mode (index 0) and own_address (index 1);
//   write only while no item is in flight.
//   The accepting edge loads the input register; the result register loads
//   from it when the frame core takes the item, and rsp_valid then rises.
//   Throughput is one item per cycle while rsp_ready takes each result; the
//   byte-wide CRC update completes in the single logic stage between the two registers.
//   If rsp_ready is low, the result register holds, then the input register
//   fills, and req_ready drops; nothing is lost.
//   Reset clears both registers' valid flags, the frame state, and sets
//   slave_mode = 1, own_address = 1.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver_unit
   import mrfr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [7:0]       rsp_position,
   output logic [7:0]       rsp_byte_value,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_frame_address,
   output logic [7:0]       rsp_function_code,
   output logic [7:0]       rsp_data_length,
   output logic [15:0]      rsp_computed_crc,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   cfg_type    cfg_ff;
   item_type   req_item;
   item_type   in_item;
   logic       in_valid;
   logic       take;
   result_type result;

   assign req_item.command = req_command;
   assign req_item.rx_byte = req_rx_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_mode  <= 1'b1;
         cfg_ff.own_address <= 8'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLAVE_MODE:  cfg_ff.slave_mode  <= csr_wdata[0];
            CSR_OWN_ADDRESS: cfg_ff.own_address <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   mrfr_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .take      (take)
   );

   mrfr_frame_core #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_frame_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (in_valid),
      .in_item    (in_item),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (result)
   );

   assign rsp_kind          = result.kind;
   assign rsp_position      = result.position;
   assign rsp_byte_value    = result.byte_value;
   assign rsp_status        = result.status;
   assign rsp_frame_address = result.frame_address;
   assign rsp_function_code = result.function_code;
   assign rsp_data_length   = result.data_length;
   assign rsp_computed_crc  = result.computed_crc;

endmodule
`default_nettype wire
